@@ hdl/pted_pkg.sv @@
`default_nettype none
package pted_pkg;

  // Scanner modes
  localparam logic [3:0] MODE_FRESH  = 4'd0;
  localparam logic [3:0] MODE_NORMAL = 4'd1;
  localparam logic [3:0] MODE_SKIP1  = 4'd2;
  localparam logic [3:0] MODE_SQUOTE = 4'd3;
  localparam logic [3:0] MODE_DQUOTE = 4'd4;
  localparam logic [3:0] MODE_LINE   = 4'd5;
  localparam logic [3:0] MODE_BLOCK  = 4'd6;
  localparam logic [3:0] MODE_BSTAR  = 4'd7;
  localparam logic [3:0] MODE_DONE   = 4'd8;

  // Character codes
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEL     = 8'h85;
  localparam logic [7:0] CH_NBSP    = 8'hA0;

  // Classes of one character
  typedef struct packed {
    logic space;
    logic graphic;
    logic squote;
    logic dquote;
    logic percent;
    logic star;
    logic slash;
    logic dot;
    logic newline;
    logic zero;
  } char_class_t;

  // Scanner state; previous character kept as the classes it matters for
  typedef struct packed {
    logic [3:0] mode;
    logic       guard;
    logic       end_seen;
    logic       prev_zero;
    logic       prev_slash;
    logic       prev_graphic;
  } scan_state_t;

  localparam scan_state_t STATE_RESET = '{
    mode: MODE_FRESH, guard: 1'b0, end_seen: 1'b0,
    prev_zero: 1'b0, prev_slash: 1'b0, prev_graphic: 1'b0
  };

endpackage
`default_nettype wire

@@ hdl/pted_if.sv @@
`default_nettype none
// Character word channel
interface pted_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// Result word channel
interface pted_result_if;
  logic valid;
  logic ready;
  logic term_end;
  logic found;
  modport source (output valid, output term_end, output found, input ready);
  modport sink   (input valid, input term_end, input found, output ready);
endinterface
`default_nettype wire

@@ hdl/prolog_term_end_detector_unit.sv @@
`default_nettype none
// Path: an accepted word is held in the input register, and its flags go on into the result register.
// Throughput: one character word per cycle while the result channel is ready; the
// scan state register closes its loop through one combinational classify-and-step layer.
// Reset: synchronous rst empties the input and result registers and returns
// the scanner to plain-text mode with no previous character and no end seen.
module prolog_term_end_detector_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  pted_char_if.sink     char_in,
  pted_result_if.source result_out
);

  logic                  in_valid;
  logic [7:0]            in_char;
  logic                  in_last;
  logic                  advance;
  pted_pkg::scan_state_t scan;
  pted_pkg::scan_state_t scan_next;
  pted_pkg::char_class_t cls;
  logic                  hit;
  logic                  found;
  logic                  out_valid;
  logic                  out_term_end;
  logic                  out_found;

  // Move the held word into the result register when it is free or draining
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign char_in.ready = !in_valid || advance;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
    if (char_in.ready && char_in.valid) begin
      in_char <= char_in.char_code;
      in_last <= char_in.is_last;
    end
  end

  pted_char_class u_class (
    .char_code (in_char),
    .cls       (cls)
  );

  pted_scan_step u_step (
    .cur      (scan),
    .cls      (cls),
    .is_last  (in_last),
    .nxt      (scan_next),
    .term_end (hit),
    .found    (found)
  );

  // Update scan state once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= pted_pkg::STATE_RESET;
    end else if (advance) begin
      scan <= scan_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_term_end <= hit;
      out_found    <= found;
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.term_end = out_term_end;
  assign result_out.found    = out_found;

  // A confirmed end always shows as found
  a_end_implies_found: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.term_end) |-> result_out.found)
    else $error("term_end without found");

  // An end inside the line parks the scanner until the line closes
  a_end_parks: assert property (@(posedge clk) disable iff (rst)
    (advance && hit && !in_last) |=> (scan.mode == pted_pkg::MODE_DONE && scan.end_seen))
    else $error("scanner not parked after end");

  // The last character of a line clears the scanner
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (scan.mode == pted_pkg::MODE_FRESH && !scan.end_seen &&
                              !scan.guard))
    else $error("scanner not cleared after last character");

  // Never take a word the result register cannot absorb
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !result_out.ready) |=> (in_valid && $stable(in_char)))
    else $error("held word lost while result stalled");

endmodule
`default_nettype wire

@@ hdl/pted_char_class.sv @@
`default_nettype none
module pted_char_class (
  input  wire logic [7:0]           char_code,
  output pted_pkg::char_class_t     cls
);

  // Decode the character into the classes the scanner tests
  always_comb begin
    cls.space   = ((char_code >= pted_pkg::CH_TAB) && (char_code <= pted_pkg::CH_CR)) ||
                  (char_code == pted_pkg::CH_SPACE) || (char_code == pted_pkg::CH_NEL) ||
                  (char_code == pted_pkg::CH_NBSP);
    cls.squote  = (char_code == pted_pkg::CH_SQUOTE);
    cls.dquote  = (char_code == pted_pkg::CH_DQUOTE);
    cls.percent = (char_code == pted_pkg::CH_PERCENT);
    cls.star    = (char_code == pted_pkg::CH_STAR);
    cls.slash   = (char_code == pted_pkg::CH_SLASH);
    cls.dot     = (char_code == pted_pkg::CH_DOT);
    cls.newline = (char_code == pted_pkg::CH_NEWLINE);
    cls.zero    = (char_code == pted_pkg::CH_ZERO);
    case (char_code)
      8'h2D, 8'h2F, 8'h2B, 8'h2A, 8'h3C, 8'h3D, 8'h3E, 8'h23, 8'h40, 8'h24,
      8'h5C, 8'h5E, 8'h26, 8'h7E, 8'h60, 8'h3A, 8'h2E, 8'h3F, 8'h7C:
        cls.graphic = 1'b1;
      default:
        cls.graphic = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/pted_scan_step.sv @@
`default_nettype none
module pted_scan_step (
  input  wire pted_pkg::scan_state_t cur,
  input  wire pted_pkg::char_class_t cls,
  input  wire logic                  is_last,
  output pted_pkg::scan_state_t      nxt,
  output logic                       term_end,
  output logic                       found
);

  logic eligible;

  // Advance the scanner by one character
  always_comb begin
    nxt      = cur;
    term_end = 1'b0;
    eligible = (cur.mode == pted_pkg::MODE_NORMAL);
    case (cur.mode)
      pted_pkg::MODE_DONE: begin
        nxt.mode = pted_pkg::MODE_DONE;
      end
      pted_pkg::MODE_SKIP1: begin
        nxt.mode = pted_pkg::MODE_FRESH;
      end
      pted_pkg::MODE_SQUOTE: begin
        if (cls.squote) nxt.mode = pted_pkg::MODE_FRESH;
      end
      pted_pkg::MODE_DQUOTE: begin
        if (cls.dquote) nxt.mode = pted_pkg::MODE_FRESH;
      end
      pted_pkg::MODE_LINE: begin
        if (cls.newline) nxt.mode = pted_pkg::MODE_FRESH;
      end
      pted_pkg::MODE_BLOCK: begin
        if (cls.star) nxt.mode = pted_pkg::MODE_BSTAR;
      end
      pted_pkg::MODE_BSTAR: begin
        if (cls.slash) nxt.mode = pted_pkg::MODE_FRESH;
        else if (!cls.star) nxt.mode = pted_pkg::MODE_BLOCK;
      end
      default: begin
        nxt.guard = 1'b0;
        if (cur.guard && cls.space) begin
          // whitespace confirms the pending dot
          term_end = 1'b1;
          nxt.mode = pted_pkg::MODE_DONE;
        end else if (cls.squote) begin
          nxt.mode = (eligible && cur.prev_zero) ? pted_pkg::MODE_SKIP1
                                                 : pted_pkg::MODE_SQUOTE;
        end else if (cls.dquote) begin
          nxt.mode = pted_pkg::MODE_DQUOTE;
        end else if (cls.percent) begin
          nxt.mode = pted_pkg::MODE_LINE;
        end else if (cls.star && eligible && cur.prev_slash) begin
          nxt.mode = pted_pkg::MODE_BLOCK;
        end else if (cls.dot && !cur.prev_graphic) begin
          if (is_last) begin
            term_end = 1'b1;
            nxt.mode = pted_pkg::MODE_DONE;
          end else begin
            nxt.guard = 1'b1;
            nxt.mode  = pted_pkg::MODE_NORMAL;
          end
        end else begin
          nxt.mode = pted_pkg::MODE_NORMAL;
        end
      end
    endcase
    if (term_end) nxt.end_seen = 1'b1;
    found            = nxt.end_seen;
    nxt.prev_zero    = cls.zero;
    nxt.prev_slash   = cls.slash;
    nxt.prev_graphic = cls.graphic;
    // drop all state after the last character of the line
    if (is_last) nxt = pted_pkg::STATE_RESET;
  end

endmodule
`default_nettype wire

@@ tb/sv/pted_line_checker.sv @@
// Watches the character and result channels, predicts the clause-end flags
// for every accepted character word and compares them with the result words.
module pted_line_checker
  import pted_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  pted_char_if   chr,
  pted_result_if res,
  output int     fail_count,
  output int     waiting
);

  localparam logic [7:0] CH_GRAVE = 8'h60;

  typedef struct packed {
    logic term_end;
    logic found;
  } line_flags_t;

  // Scanner shadow state
  logic [3:0]  scan_mode;
  logic [7:0]  prev_ch;
  logic        dot_pending;
  logic        line_ended;

  line_flags_t flags_q[$];
  int          misses = 0;

  function automatic logic is_graphic(input logic [7:0] c);
    case (c)
      "-", "/", "+", "*", "<", "=", ">", "#", "@", "$", "\\", "^", "&", "~",
      CH_GRAVE, ":", ".", "?", "|": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_NEL ||
           c == CH_NBSP;
  endfunction

  function automatic void clear_scan();
    scan_mode   = MODE_FRESH;
    prev_ch     = 8'h00;
    dot_pending = 1'b0;
    line_ended  = 1'b0;
  endfunction

  // Advance the scanner by one character and return the expected flags
  function automatic line_flags_t scan_char(input logic [7:0] c, input logic last);
    line_flags_t f;
    logic        hit;
    logic        plain;
    logic        closed;
    hit    = 1'b0;
    closed = 1'b0;
    case (scan_mode)
      MODE_DONE: ;
      MODE_SKIP1:  scan_mode = MODE_FRESH;
      MODE_SQUOTE: if (c == CH_SQUOTE) scan_mode = MODE_FRESH;
      MODE_DQUOTE: if (c == CH_DQUOTE) scan_mode = MODE_FRESH;
      MODE_LINE:   if (c == CH_NEWLINE) scan_mode = MODE_FRESH;
      MODE_BLOCK:  if (c == CH_STAR) scan_mode = MODE_BSTAR;
      MODE_BSTAR: begin
        if (c == CH_SLASH) scan_mode = MODE_FRESH;
        else if (c != CH_STAR) scan_mode = MODE_BLOCK;
      end
      default: begin
        // plain text; a character code or block comment needs a scanned prefix
        plain = (scan_mode == MODE_NORMAL);
        if (dot_pending) begin
          dot_pending = 1'b0;
          if (is_blank(c)) begin
            hit       = 1'b1;
            scan_mode = MODE_DONE;
            closed    = 1'b1;
          end
        end
        if (!closed) begin
          if (c == CH_SQUOTE) begin
            scan_mode = (plain && prev_ch == CH_ZERO) ? MODE_SKIP1 : MODE_SQUOTE;
          end else if (c == CH_DQUOTE) begin
            scan_mode = MODE_DQUOTE;
          end else if (c == CH_PERCENT) begin
            scan_mode = MODE_LINE;
          end else if (c == CH_STAR && plain && prev_ch == CH_SLASH) begin
            scan_mode = MODE_BLOCK;
          end else if (c == CH_DOT && !is_graphic(prev_ch)) begin
            if (last) begin
              hit       = 1'b1;
              scan_mode = MODE_DONE;
            end else begin
              dot_pending = 1'b1;
              scan_mode   = MODE_NORMAL;
            end
          end else begin
            scan_mode = MODE_NORMAL;
          end
        end
      end
    endcase
    if (hit) line_ended = 1'b1;
    f.term_end = hit;
    f.found    = line_ended;
    prev_ch    = c;
    if (last) clear_scan();
    return f;
  endfunction

  // Check result words first, then predict from the character word
  always @(posedge clk) begin : watch
    line_flags_t want;
    if (rst) begin
      clear_scan();
      flags_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (flags_q.size() == 0) begin
          $display("%0t: unexpected result word, term_end %0b found %0b",
                   $time, res.term_end, res.found);
          misses++;
        end else begin
          want = flags_q.pop_front();
          if (res.term_end !== want.term_end) begin
            $display("%0t: term_end mismatch, expected %0b actual %0b",
                     $time, want.term_end, res.term_end);
            misses++;
          end
          if (res.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, res.found);
            misses++;
          end
        end
      end
      if (chr.valid && chr.ready) begin
        flags_q.push_back(scan_char(chr.char_code, chr.is_last));
      end
    end
    fail_count <= misses;
    waiting    <= flags_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Feeds Prolog-like text lines into the clause-end detector and gives the verdict.
module tb;
  import pted_pkg::*;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_GRAVE   = 8'h60;
  localparam int         ITEM_GOAL  = 1925;

  logic clk;
  logic rst;
  int   fail_count;
  int   waiting;

  pted_char_if   chr ();
  pted_result_if res ();

  prolog_term_end_detector_unit dut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (chr),
    .result_out (res)
  );

  pted_line_checker chk (
    .clk        (clk),
    .rst        (rst),
    .chr        (chr),
    .res        (res),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stall pattern: a randomly picked style, switched periodically
  int stall_tick  = 0;
  int stall_style = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 61 == 0) stall_style = $urandom_range(0, 4);
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      case (stall_style)
        0, 1: res.ready <= 1'b1;
        2:    res.ready <= (stall_tick % 3 != 0);
        3:    res.ready <= $urandom_range(0, 1);
        default: res.ready <= (stall_tick % 16 == 0);
      endcase
    end
  end

  logic [7:0] line_buf[$];
  int         burst_left = 0;
  int         sent = 0;

  // Send one character word, idling between bursts
  task automatic put_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        chr.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    chr.valid     <= 1'b1;
    chr.char_code <= c;
    chr.is_last   <= last;
    @(posedge clk);
    while (!chr.ready) @(posedge clk);
    sent++;
  endtask

  // Send the buffered line, marking its final character
  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      put_char(line_buf[i], i == line_buf.size() - 1);
    end
    line_buf.delete();
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(CH_TAB, CH_CR));
      1, 2:    return CH_SPACE;
      default: return $urandom_range(0, 1) ? CH_NEL : CH_NBSP;
    endcase
  endfunction

  function automatic void push_graphic();
    string ops;
    int    k;
    ops = "-/+*<=>#@$\\^&~:.?|";
    k   = $urandom_range(0, ops.len());
    line_buf.push_back((k == ops.len()) ? CH_GRAVE : 8'(ops[k]));
  endfunction

  // Quoted or commented body that mixes in its own closing characters
  function automatic void push_filler();
    string mix;
    mix = "ab.*/ %0'\"\n\t";
    repeat ($urandom_range(0, 5)) line_buf.push_back(mix[$urandom_range(0, mix.len() - 1)]);
  endfunction

  function automatic void push_token();
    case ($urandom_range(0, 13))
      0, 1: repeat ($urandom_range(1, 4)) line_buf.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
      2:    line_buf.push_back(pick_blank());
      3:    line_buf.push_back(CH_DOT);
      4:    push_graphic();
      5: begin
        line_buf.push_back(CH_SQUOTE);
        push_filler();
        if ($urandom_range(0, 4) != 0) line_buf.push_back(CH_SQUOTE);
      end
      6: begin
        line_buf.push_back(CH_DQUOTE);
        push_filler();
        if ($urandom_range(0, 4) != 0) line_buf.push_back(CH_DQUOTE);
      end
      7: begin
        line_buf.push_back(CH_PERCENT);
        push_filler();
        if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_NEWLINE);
      end
      8: begin
        line_buf.push_back(CH_SLASH);
        line_buf.push_back(CH_STAR);
        push_filler();
        if ($urandom_range(0, 4) != 0) begin
          line_buf.push_back(CH_STAR);
          line_buf.push_back(CH_SLASH);
        end
      end
      9: begin
        line_buf.push_back(CH_ZERO);
        line_buf.push_back(CH_SQUOTE);
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
      10, 11: begin
        line_buf.push_back(CH_DOT);
        line_buf.push_back(pick_blank());
      end
      12:      line_buf.push_back(8'($urandom_range(0, 255)));
      default: line_buf.push_back($urandom_range(0, 1) ? CH_ZERO : CH_SLASH);
    endcase
  endfunction

  initial begin : stimulus
    int target;
    rst           = 1'b1;
    chr.valid     = 1'b0;
    chr.char_code = 8'h00;
    chr.is_last   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Dot as the only character of a line
    push_text(".");
    send_line();
    // Tab confirms the dot; the rest of the line is ignored
    push_text("a.\tz");
    send_line();
    // Character code swallows the dot; the final dot ends the line
    push_text("0'. .");
    send_line();
    // Slash right after the opening does not close; the dot after the close follows a graphic slash
    push_text("/*/.*/.");
    send_line();
    // Line comment up to newline, then a dot with no graphic before it
    push_text("%.\n.");
    send_line();
    // Extreme codes around an unconfirmed dot
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_DOT);
    line_buf.push_back(8'hFF);
    send_line();

    // Random lines built from clause-like tokens and noise
    while (sent < ITEM_GOAL) begin
      target = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
      while (line_buf.size() < target) push_token();
      send_line();
    end

    // Drain and let the pipeline settle; the pending count is registered
    chr.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
